// ===== hw/rtl/wstfd_pkg.sv =====
// Shared types and constants for the WebSocket text frame deframer.
package wstfd_pkg;

	// Result kinds
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_EMPTY   = 2'd1;
	localparam logic [1:0] KIND_CLOSE   = 2'd2;
	localparam logic [1:0] KIND_END     = 2'd3;

	// Frame header codes
	localparam logic [3:0] OPC_TEXT  = 4'h1;
	localparam logic [3:0] OPC_CLOSE = 4'h8;
	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;

	localparam logic [31:0] DEFAULT_MAX_TEXT = 32'd1048576;

	// Queue between parser and output stage
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef enum logic [4:0] {
		PH_HDR0 = 5'b00001,
		PH_HDR1 = 5'b00010,
		PH_EXT  = 5'b00100,
		PH_KEY  = 5'b01000,
		PH_DATA = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [7:0] key;
		logic       last;
	} q_entry_t;

	typedef struct packed {
		logic link_open;
		logic push;
	} front_status_t;

endpackage

// ===== hw/rtl/wstfd_front.sv =====
// Header parser: accepts bytes, tracks frame state and classifies each byte.
module wstfd_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  logic [7:0]               data_byte,
	input  logic                     stream_end,
	input  logic                     q_full,
	input  logic [31:0]              max_text_length,
	output wstfd_pkg::q_entry_t      q_entry,
	output wstfd_pkg::front_status_t status
);

	logic              link_open_q;
	wstfd_pkg::phase_t phase_q;
	logic [3:0]        opcode_q;
	logic              mask_present_q;
	logic [3:0]        ext_left_q;
	logic [31:0]       mask_key_q;
	logic [63:0]       remaining_q;
	logic [1:0]        mask_pos_q;
	logic              skip_q;

	logic              n_link_open;
	wstfd_pkg::phase_t n_phase;
	logic [3:0]        n_opcode;
	logic              n_mask_present;
	logic [3:0]        n_ext_left;
	logic [31:0]       n_mask_key;
	logic [63:0]       n_remaining;
	logic [1:0]        n_mask_pos;
	logic              n_skip;

	logic                accept;
	logic                emit;
	wstfd_pkg::q_entry_t ent;
	logic                len_done;
	logic                hdr_done;
	logic [63:0]         r_sel;
	logic [63:0]         r_ext;
	logic [6:0]          len7;

	assign accept = push & ~q_full;
	assign len7   = data_byte[6:0];
	assign r_ext  = {remaining_q[55:0], data_byte};

	always_comb begin
		n_link_open    = link_open_q;
		n_phase        = phase_q;
		n_opcode       = opcode_q;
		n_mask_present = mask_present_q;
		n_ext_left     = ext_left_q;
		n_mask_key     = mask_key_q;
		n_remaining    = remaining_q;
		n_mask_pos     = mask_pos_q;
		n_skip         = skip_q;
		emit           = 1'b0;
		ent            = '0;
		len_done       = 1'b0;
		hdr_done       = 1'b0;
		r_sel          = remaining_q;

		if (accept && link_open_q) begin
			if (stream_end) begin
				n_link_open = 1'b0;
				emit        = 1'b1;
				ent.kind    = wstfd_pkg::KIND_END;
			end else begin
				unique case (phase_q)
					wstfd_pkg::PH_HDR1: begin
						n_mask_present = data_byte[7];
						n_remaining    = '0;
						if (len7 == wstfd_pkg::LEN_EXT16) begin
							n_ext_left = wstfd_pkg::EXT16_BYTES;
							n_phase    = wstfd_pkg::PH_EXT;
						end else if (len7 == wstfd_pkg::LEN_EXT64) begin
							n_ext_left = wstfd_pkg::EXT64_BYTES;
							n_phase    = wstfd_pkg::PH_EXT;
						end else begin
							r_sel       = {57'd0, len7};
							n_remaining = r_sel;
							len_done    = 1'b1;
						end
					end
					wstfd_pkg::PH_EXT: begin
						r_sel       = r_ext;
						n_remaining = r_ext;
						n_ext_left  = ext_left_q - 4'd1;
						len_done    = (ext_left_q == 4'd1);
					end
					wstfd_pkg::PH_KEY: begin
						n_mask_key = {mask_key_q[23:0], data_byte};
						n_mask_pos = mask_pos_q + 2'd1;
						hdr_done   = (mask_pos_q == 2'd3);
					end
					wstfd_pkg::PH_DATA: begin
						if (!skip_q) begin
							emit      = 1'b1;
							ent.kind  = wstfd_pkg::KIND_PAYLOAD;
							ent.data  = data_byte;
							ent.key   = mask_key_q[5'd24 - {mask_pos_q, 3'd0} +: 8];
							ent.last  = (remaining_q == 64'd1);
						end
						n_remaining = remaining_q - 64'd1;
						n_mask_pos  = mask_pos_q + 2'd1;
						if (remaining_q == 64'd1) begin
							n_phase = wstfd_pkg::PH_HDR0;
						end
					end
					default: begin
						n_opcode       = data_byte[3:0];
						n_mask_present = 1'b0;
						n_mask_key     = '0;
						n_mask_pos     = '0;
						n_remaining    = '0;
						n_ext_left     = '0;
						n_skip         = 1'b0;
						n_phase        = wstfd_pkg::PH_HDR1;
					end
				endcase

				// Length known: fetch the mask key or finish the header.
				if (len_done) begin
					if (n_mask_present) begin
						n_phase    = wstfd_pkg::PH_KEY;
						n_mask_pos = '0;
					end else begin
						hdr_done = 1'b1;
					end
				end

				if (hdr_done) begin
					n_mask_pos = '0;
					if (opcode_q == wstfd_pkg::OPC_CLOSE) begin
						n_link_open = 1'b0;
						n_phase     = wstfd_pkg::PH_HDR0;
						emit        = 1'b1;
						ent.kind    = wstfd_pkg::KIND_CLOSE;
					end else begin
						n_skip = (opcode_q != wstfd_pkg::OPC_TEXT) ||
						         (r_sel > {32'd0, max_text_length});
						if (r_sel == 64'd0) begin
							n_phase = wstfd_pkg::PH_HDR0;
							if (!n_skip) begin
								emit     = 1'b1;
								ent.kind = wstfd_pkg::KIND_EMPTY;
								ent.last = 1'b1;
							end
						end else begin
							n_phase = wstfd_pkg::PH_DATA;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_open_q    <= 1'b1;
			phase_q        <= wstfd_pkg::PH_HDR0;
			opcode_q       <= '0;
			mask_present_q <= 1'b0;
			ext_left_q     <= '0;
			mask_key_q     <= '0;
			remaining_q    <= '0;
			mask_pos_q     <= '0;
			skip_q         <= 1'b0;
		end else begin
			link_open_q    <= n_link_open;
			phase_q        <= n_phase;
			opcode_q       <= n_opcode;
			mask_present_q <= n_mask_present;
			ext_left_q     <= n_ext_left;
			mask_key_q     <= n_mask_key;
			remaining_q    <= n_remaining;
			mask_pos_q     <= n_mask_pos;
			skip_q         <= n_skip;
		end
	end

	assign q_entry          = ent;
	assign status.push      = emit;
	assign status.link_open = link_open_q;

endmodule

// ===== hw/rtl/wstfd_queue.sv =====
// Short queue of classified transactions between the parser and the output stage.
module wstfd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  wstfd_pkg::q_entry_t wr_entry,
	input  logic                rd_en,
	output wstfd_pkg::q_entry_t rd_entry,
	output logic                rd_valid,
	output logic                full
);

	wstfd_pkg::q_entry_t             mem_q [wstfd_pkg::QDEPTH];
	logic [wstfd_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [wstfd_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [wstfd_pkg::QPTR_W:0]      count_q;

	assign full     = (count_q == (wstfd_pkg::QPTR_W+1)'(wstfd_pkg::QDEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + wstfd_pkg::QPTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + wstfd_pkg::QPTR_W'(1);
			end
			unique case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + (wstfd_pkg::QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (wstfd_pkg::QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/wstfd_back.sv =====
// Output stage: unmask payload bytes and hold the oldest result for the consumer.
module wstfd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  wstfd_pkg::q_entry_t q_head,
	output logic                q_take,
	input  logic                pop,
	output logic                empty,
	output logic [1:0]          kind,
	output logic [7:0]          payload_byte,
	output logic                last_of_message
);

	logic       valid_q;
	logic [1:0] kind_q;
	logic [7:0] byte_q;
	logic       last_q;

	assign q_take = q_valid & (~valid_q | pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_take) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_take) begin
			kind_q <= q_head.kind;
			last_q <= q_head.last;
			byte_q <= (q_head.kind == wstfd_pkg::KIND_PAYLOAD) ? (q_head.data ^ q_head.key)
			                                                    : 8'd0;
		end
	end

	assign empty           = ~valid_q;
	assign kind            = kind_q;
	assign payload_byte    = byte_q;
	assign last_of_message = last_q;

endmodule

// ===== hw/rtl/websocket_text_frame_deframer.sv =====
// Top level of the WebSocket text frame deframer.
//
// Input channel: received bytes, one per transaction, taken when push is high
// and full is low. stream_end marks a dropped connection; its data byte is
// ignored. Result channel: the oldest result sits on kind, payload_byte and
// last_of_message while empty is low, and is consumed when pop is high.
// Configuration: cfg_write loads cfg_data into max_text_length at once; write
// only while the block is idle.
// A byte that yields a result passes it through the queue to the output register.
// Throughput: one byte every cycle while full is low; header bytes, skipped
// frames and bytes after close give no result.
// Reset: max_text_length returns to 1 MiB, the link is open and the parser
// waits for the first header byte; the queue and output register are empty.
// Consumer stall: a four-entry queue plus the output register absorb results;
// once they fill, full rises and input transactions wait.
// After a close frame or stream end, bytes are still taken and dropped.
module websocket_text_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        stream_end,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic [7:0]  payload_byte,
	output logic        last_of_message,
	input  logic        cfg_write,
	input  logic [31:0] cfg_data
);

	logic [31:0]              max_text_length_q;
	wstfd_pkg::q_entry_t      f_entry;
	wstfd_pkg::front_status_t f_status;
	wstfd_pkg::q_entry_t      q_head;
	logic                     q_valid;
	logic                     q_take;
	logic                     q_full;

	// Hold the length limit until the next write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_text_length_q <= wstfd_pkg::DEFAULT_MAX_TEXT;
		end else if (cfg_write) begin
			max_text_length_q <= cfg_data;
		end
	end

	// Parser stalls whenever the queue cannot take a result.
	assign full = q_full;

	wstfd_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.data_byte       (data_byte),
		.stream_end      (stream_end),
		.q_full          (q_full),
		.max_text_length (max_text_length_q),
		.q_entry         (f_entry),
		.status          (f_status)
	);

	wstfd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (f_status.push),
		.wr_entry (f_entry),
		.rd_en    (q_take),
		.rd_entry (q_head),
		.rd_valid (q_valid),
		.full     (q_full)
	);

	wstfd_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_head          (q_head),
		.q_take          (q_take),
		.pop             (pop),
		.empty           (empty),
		.kind            (kind),
		.payload_byte    (payload_byte),
		.last_of_message (last_of_message)
	);

	// The parser never writes into a full queue.
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		f_status.push |-> !q_full)
		else $error("parser pushed into a full queue");

	// Once closed, the link stays closed.
	a_link_stays_closed: assert property (@(posedge clk) disable iff (!arst_n)
		!f_status.link_open |=> !f_status.link_open)
		else $error("link reopened after close");

	// A closed link produces no further results.
	a_no_result_after_close: assert property (@(posedge clk) disable iff (!arst_n)
		!f_status.link_open |-> !f_status.push)
		else $error("result produced after link closed");

	// The link closes only through a close or stream-end result.
	a_close_reported: assert property (@(posedge clk) disable iff (!arst_n)
		(f_status.link_open && !f_status.push) |=> f_status.link_open)
		else $error("link closed without a result");

endmodule
